FILE: rtl/core/dual_channel_window_average_assert.svh
// Assertion macros for the window average block.
// Used by modules that need a clk and rst_n in scope; no other dependencies.
`ifndef DUAL_CHANNEL_WINDOW_AVERAGE_ASSERT_SVH
`define DUAL_CHANNEL_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DCWA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dcwa_pkg.sv
// Shared constants, types and state encoding for the window average block.
// No dependencies.
package dcwa_pkg;

    localparam int WINDOW  = 20;
    localparam int TEMP_W  = 12;
    localparam int HUM_W   = 10;
    localparam int FILL_W  = 5;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Sums hold WINDOW full-scale samples exactly.
    localparam int T_SUM_W = $clog2(WINDOW * (2 ** (TEMP_W - 1)) + 1) + 1;
    localparam int H_SUM_W = $clog2(WINDOW * (2 ** HUM_W - 1) + 1);
    localparam int DIV_W   = T_SUM_W;
    localparam int ITER_W  = $clog2(DIV_W);

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic              temperature_ok;
        logic [HUM_W-1:0]  humidity;
        logic              humidity_ok;
    } ring_entry_t;

    typedef struct packed {
        logic clear;
        logic add;
    } ring_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD_T,
        ST_DIV_T,
        ST_LOAD_H,
        ST_DIV_H,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/core/dcwa_if.sv
// Valid/ready channel interfaces for samples and results.
// Depends on dcwa_pkg for field widths.
interface dcwa_sample_if
    import dcwa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [TEMP_W-1:0] temperature;
    logic              temperature_ok;
    logic [HUM_W-1:0]  humidity;
    logic              humidity_ok;

    modport source (
        output valid, command, temperature, temperature_ok, humidity, humidity_ok,
        input  ready
    );
    modport sink (
        input  valid, command, temperature, temperature_ok, humidity, humidity_ok,
        output ready
    );
endinterface

interface dcwa_result_if
    import dcwa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] mean_temperature;
    logic [HUM_W-1:0]  mean_humidity;
    logic              mean_ok;
    logic [FILL_W-1:0] fill_count;

    modport source (
        output valid, mean_temperature, mean_humidity, mean_ok, fill_count,
        input  ready
    );
    modport sink (
        input  valid, mean_temperature, mean_humidity, mean_ok, fill_count,
        output ready
    );
endinterface

FILE: rtl/core/dcwa_ring.sv
// Sample ring memory with write slot, entry count and both running sums.
// Depends on dcwa_pkg.
module dcwa_ring
    import dcwa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ring_ctl_t                 ctl,
    input  ring_entry_t               entry,
    output logic [CNT_W-1:0]          count,
    output logic signed [T_SUM_W-1:0] temp_sum,
    output logic [H_SUM_W-1:0]        hum_sum
);

    ring_entry_t               mem [WINDOW];
    ring_entry_t               old_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         slot_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [T_SUM_W-1:0] temp_sum_reg;
    logic signed [T_SUM_W-1:0] temp_sum_next;
    logic [H_SUM_W-1:0]        hum_sum_reg;
    logic [H_SUM_W-1:0]        hum_sum_next;
    logic                      full;
    logic signed [T_SUM_W-1:0] t_sub;
    logic signed [T_SUM_W-1:0] t_add;
    logic [H_SUM_W-1:0]        h_sub;
    logic [H_SUM_W-1:0]        h_add;

    // Read the current slot every cycle; it holds the oldest entry once full.
    always_ff @(posedge clk)
    begin
        if (ctl.add)
        begin
            mem[slot_reg] <= entry;
        end
        old_reg <= mem[slot_reg];
    end

    assign full = (count_reg == CNT_W'(WINDOW));

    always_comb
    begin
        t_sub = '0;
        h_sub = '0;
        t_add = '0;
        h_add = '0;
        if (full && old_reg.temperature_ok)
        begin
            t_sub = {{(T_SUM_W-TEMP_W){old_reg.temperature[TEMP_W-1]}}, old_reg.temperature};
        end
        if (full && old_reg.humidity_ok)
        begin
            h_sub = {{(H_SUM_W-HUM_W){1'b0}}, old_reg.humidity};
        end
        if (entry.temperature_ok)
        begin
            t_add = {{(T_SUM_W-TEMP_W){entry.temperature[TEMP_W-1]}}, entry.temperature};
        end
        if (entry.humidity_ok)
        begin
            h_add = {{(H_SUM_W-HUM_W){1'b0}}, entry.humidity};
        end
    end

    always_comb
    begin
        slot_next     = slot_reg;
        count_next    = count_reg;
        temp_sum_next = temp_sum_reg;
        hum_sum_next  = hum_sum_reg;
        priority if (ctl.clear)
        begin
            slot_next     = '0;
            count_next    = '0;
            temp_sum_next = '0;
            hum_sum_next  = '0;
        end
        else if (ctl.add)
        begin
            slot_next     = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            count_next    = full ? count_reg : count_reg + 1'b1;
            temp_sum_next = temp_sum_reg - t_sub + t_add;
            hum_sum_next  = hum_sum_reg - h_sub + h_add;
        end
        else
        begin
            // Hold slot, count and sums.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            count_reg    <= '0;
            temp_sum_reg <= '0;
            hum_sum_reg  <= '0;
        end
        else
        begin
            slot_reg     <= slot_next;
            count_reg    <= count_next;
            temp_sum_reg <= temp_sum_next;
            hum_sum_reg  <= hum_sum_next;
        end
    end

    assign count    = count_reg;
    assign temp_sum = temp_sum_reg;
    assign hum_sum  = hum_sum_reg;

endmodule

FILE: rtl/core/dcwa_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, DIV_W quotient bits.
// Depends on dcwa_pkg.
module dcwa_div
    import dcwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              q_bit;

    // Shift the next dividend bit into the remainder and try the subtract.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign q_bit = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        priority if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIV_W-2:0], q_bit};
            rem_next  = q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            // Hold quotient and remainder while idle.
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/dual_channel_window_average.sv
// Top level of the dual-channel window average: control sequencer and result register.
// Depends on dcwa_pkg, dcwa_if, dcwa_ring, dcwa_div and the assertion macro header.
//
// Usage:
//   sample channel (sink): one transaction per sensor reading. command 0 adds the
//   temperature/humidity pair (each with its own valid flag) to a window of the
//   last WINDOW entries; command 1 empties the window and zeroes both sums.
//   result channel (source): one transaction per sample transaction, carrying the
//   rounded average of each channel over the window, the fill count and mean_ok
//   (low, with both averages zero, while the window is empty).
// Timing:
//   result.valid rises once the sequencer has passed through ST_UPDATE, ST_LOAD_T,
//   ST_DIV_T, ST_LOAD_H, ST_DIV_H and ST_DONE after a sample is accepted;
//   sample.ready returns the cycle after the result is loaded. The bit-serial
//   divider runs once per channel, one quotient bit per cycle.
// Reset:
//   rst_n clears the window, sums, sequencer and result valid; the ring contents
//   are not cleared, nor need to be, since a slot's old entry is used only once the window is full.
// Stall:
//   a new sample is accepted while a result waits; the finished next result
//   holds in the sequencer until result.ready frees the output register.
`include "dual_channel_window_average_assert.svh"

module dual_channel_window_average
    import dcwa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dcwa_sample_if.sink   sample,
    dcwa_result_if.source result
);

    state_t                    state_reg;
    state_t                    state_next;
    logic                      cmd_reg;
    ring_entry_t               smp_reg;
    logic                      t_neg_reg;
    logic [TEMP_W-1:0]         q_t_reg;
    logic                      res_valid_reg;
    logic [TEMP_W-1:0]         res_t_reg;
    logic [HUM_W-1:0]          res_h_reg;
    logic                      res_ok_reg;
    logic [FILL_W-1:0]         res_fill_reg;

    ring_ctl_t                 ring_ctl;
    logic [CNT_W-1:0]          ring_count;
    logic signed [T_SUM_W-1:0] temp_sum;
    logic [H_SUM_W-1:0]        hum_sum;

    logic                      div_start;
    logic                      div_done;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIV_W-1:0]          div_quotient;
    logic [DIV_W-1:0]          half_count;
    logic [DIV_W-1:0]          temp_mag;

    logic                      accept;
    logic                      capture_t;
    logic                      res_load;
    logic                      mean_ok;
    logic [TEMP_W-1:0]         mean_t;
    logic [HUM_W-1:0]          mean_h;

    dcwa_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .entry    (smp_reg),
        .count    (ring_count),
        .temp_sum (temp_sum),
        .hum_sum  (hum_sum)
    );

    dcwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (ring_count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Round to nearest, ties away from zero: divide |sum| + count/2.
    assign half_count = DIV_W'(ring_count >> 1);
    assign temp_mag   = temp_sum[T_SUM_W-1] ? DIV_W'(-temp_sum) : DIV_W'(temp_sum);
    assign div_dividend = (state_reg == ST_LOAD_T)
                        ? temp_mag + half_count
                        : DIV_W'(hum_sum) + half_count;

    assign accept = sample.valid && sample.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_LOAD_T;
            ST_LOAD_T: state_next = ST_DIV_T;
            ST_DIV_T:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD_H;
                end
            end
            ST_LOAD_H: state_next = ST_DIV_H;
            ST_DIV_H:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        sample.ready   = 1'b0;
        ring_ctl.clear = 1'b0;
        ring_ctl.add   = 1'b0;
        div_start      = 1'b0;
        capture_t      = 1'b0;
        res_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:   sample.ready = 1'b1;
            ST_UPDATE:
            begin
                ring_ctl.clear = cmd_reg;
                ring_ctl.add   = !cmd_reg;
            end
            ST_LOAD_T: div_start = 1'b1;
            ST_DIV_T:  capture_t = div_done;
            ST_LOAD_H: div_start = 1'b1;
            ST_DIV_H:  ;
            ST_DONE:   res_load = !res_valid_reg || result.ready;
            default:   ;
        endcase
    end

    assign mean_ok = (ring_count != '0);
    assign mean_t  = mean_ok ? (t_neg_reg ? -q_t_reg : q_t_reg) : '0;
    assign mean_h  = mean_ok ? div_quotient[HUM_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg                <= sample.command;
            smp_reg.temperature    <= sample.temperature;
            smp_reg.temperature_ok <= sample.temperature_ok;
            smp_reg.humidity       <= sample.humidity;
            smp_reg.humidity_ok    <= sample.humidity_ok;
        end
        if (div_start && (state_reg == ST_LOAD_T))
        begin
            t_neg_reg <= temp_sum[T_SUM_W-1];
        end
        if (capture_t)
        begin
            q_t_reg <= div_quotient[TEMP_W-1:0];
        end
        if (res_load)
        begin
            res_t_reg    <= mean_t;
            res_h_reg    <= mean_h;
            res_ok_reg   <= mean_ok;
            res_fill_reg <= FILL_W'(ring_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.mean_temperature = res_t_reg;
    assign result.mean_humidity    = res_h_reg;
    assign result.mean_ok          = res_ok_reg;
    assign result.fill_count       = res_fill_reg;

    `DCWA_ASSERT_SAME(a_no_overwrite, res_load, !res_valid_reg || result.ready, "result overwritten while pending")
    `DCWA_ASSERT_SAME(a_done_in_wait, div_done, state_reg == ST_DIV_T || state_reg == ST_DIV_H, "divider finished outside a wait state")
    `DCWA_ASSERT_SAME(a_count_bound, 1'b1, ring_count <= CNT_W'(WINDOW), "entry count above window size")
    `DCWA_ASSERT_NEXT(a_clear_empties, ring_ctl.clear, ring_count == '0 && temp_sum == '0 && hum_sum == '0, "clear left state in the window")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for dual_channel_window_average: a directed stimulus table, then
// random samples under several idle and stall mixes, checked against a window predictor.
// Depends on dcwa_pkg, the channel interfaces in dcwa_if and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_top
    import dcwa_pkg::*;
;

    localparam bit CMD_ADD   = 1'b0;
    localparam bit CMD_CLEAR = 1'b1;

    localparam int PHASE_ITEMS  = 330;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        bit                     command;
        bit signed [TEMP_W-1:0] temperature;
        bit                     temperature_ok;
        bit [HUM_W-1:0]         humidity;
        bit                     humidity_ok;
    } sample_t;

    typedef struct {
        bit [TEMP_W-1:0] mean_temperature;
        bit [HUM_W-1:0]  mean_humidity;
        bit              mean_ok;
        bit [FILL_W-1:0] fill_count;
    } mean_t;

    typedef struct {
        sample_t s;
        bit      typed;
        mean_t   want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dcwa_sample_if sample_ch ();
    dcwa_result_if result_ch ();

    dual_channel_window_average uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: its own copy of the window.
    sample_t   window_ring [WINDOW];
    int        window_slot;
    int        window_count;
    int        window_t_sum;
    int        window_h_sum;

    mean_t     mean_queue [$];
    stim_row_t directed_rows [$];
    int        failures = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_active = 1'b0;
    event      hold_start;

    function automatic int round_div(int sum, int cnt);
        int mag;
        int q;
        mag = (sum < 0) ? -sum : sum;
        q = (mag + cnt / 2) / cnt;
        return (sum < 0) ? -q : q;
    endfunction

    function automatic mean_t predict_window(sample_t s);
        mean_t r;
        int    mt;
        int    mh;
        mt = 0;
        mh = 0;
        if (s.command == CMD_CLEAR)
        begin
            window_slot = 0;
            window_count = 0;
            window_t_sum = 0;
            window_h_sum = 0;
        end
        else
        begin
            // Full window: retire the oldest entry before overwriting it.
            if (window_count >= WINDOW)
            begin
                if (window_ring[window_slot].temperature_ok)
                    window_t_sum -= int'(window_ring[window_slot].temperature);
                if (window_ring[window_slot].humidity_ok)
                    window_h_sum -= int'(window_ring[window_slot].humidity);
            end
            else
                window_count++;
            window_ring[window_slot] = s;
            if (s.temperature_ok)
                window_t_sum += int'(s.temperature);
            if (s.humidity_ok)
                window_h_sum += int'(s.humidity);
            window_slot = (window_slot + 1 == WINDOW) ? 0 : window_slot + 1;
        end
        if (window_count > 0)
        begin
            mt = round_div(window_t_sum, window_count);
            mh = round_div(window_h_sum, window_count);
        end
        r.mean_temperature = mt[TEMP_W-1:0];
        r.mean_humidity    = mh[HUM_W-1:0];
        r.mean_ok          = (window_count > 0);
        r.fill_count       = window_count[FILL_W-1:0];
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      t;
        int      h;
        s.command = ($urandom_range(39) == 0) ? CMD_CLEAR : CMD_ADD;
        // Mostly in the sensor range, sometimes any bit pattern.
        if ($urandom_range(9) < 8)
            t = int'($urandom_range(1650)) - 400;
        else
            t = int'($urandom());
        if ($urandom_range(9) < 8)
            h = int'($urandom_range(1000));
        else
            h = int'($urandom());
        s.temperature    = t[TEMP_W-1:0];
        s.humidity       = h[HUM_W-1:0];
        s.temperature_ok = ($urandom_range(99) < 85);
        s.humidity_ok    = ($urandom_range(99) < 85);
        return s;
    endfunction

    task automatic put_row(bit cmd, int t, bit t_ok, int h, bit h_ok,
                           bit typed, int mt, int mh, bit m_ok, int fill);
        stim_row_t r;
        r.s.command                = cmd;
        r.s.temperature            = t[TEMP_W-1:0];
        r.s.temperature_ok         = t_ok;
        r.s.humidity               = h[HUM_W-1:0];
        r.s.humidity_ok            = h_ok;
        r.typed                    = typed;
        r.want.mean_temperature    = mt[TEMP_W-1:0];
        r.want.mean_humidity       = mh[HUM_W-1:0];
        r.want.mean_ok             = m_ok;
        r.want.fill_count          = fill[FILL_W-1:0];
        directed_rows.push_back(r);
    endtask

    task automatic send_sample(sample_t s, bit typed, mean_t want);
        mean_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.command        <= s.command;
        sample_ch.temperature    <= s.temperature;
        sample_ch.temperature_ok <= s.temperature_ok;
        sample_ch.humidity       <= s.humidity;
        sample_ch.humidity_ok    <= s.humidity_ok;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        // Transaction accepted at this edge.
        predicted = predict_window(s);
        if (typed)
            mean_queue.push_back(want);
        else
            mean_queue.push_back(predicted);
    endtask

    task automatic run_random(int n, int send_pct, int recv_pct);
        mean_t none;
        none = '{default: 0};
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n)
            send_sample(random_sample(), 1'b0, none);
    endtask

    task automatic check_mean();
        mean_t want;
        if (mean_queue.size() == 0)
        begin
            $error("result transaction with no expectation waiting");
            failures++;
        end
        else
        begin
            want = mean_queue.pop_front();
            if (result_ch.mean_temperature !== want.mean_temperature)
            begin
                $error("mean_temperature: expected %0d, actual %0d",
                       $signed(want.mean_temperature), $signed(result_ch.mean_temperature));
                failures++;
            end
            if (result_ch.mean_humidity !== want.mean_humidity)
            begin
                $error("mean_humidity: expected %0d, actual %0d",
                       want.mean_humidity, result_ch.mean_humidity);
                failures++;
            end
            if (result_ch.mean_ok !== want.mean_ok)
            begin
                $error("mean_ok: expected %0d, actual %0d", want.mean_ok, result_ch.mean_ok);
                failures++;
            end
            if (result_ch.fill_count !== want.fill_count)
            begin
                $error("fill_count: expected %0d, actual %0d",
                       want.fill_count, result_ch.fill_count);
                failures++;
            end
        end
    endtask

    // Receiver: check accepted results, then pick ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_mean();
        if (hold_active)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    always
    begin
        @(hold_start);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n                    = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.command        = CMD_ADD;
        sample_ch.temperature    = '0;
        sample_ch.temperature_ok = 1'b0;
        sample_ch.humidity       = '0;
        sample_ch.humidity_ok    = 1'b0;
        window_slot  = 0;
        window_count = 0;
        window_t_sum = 0;
        window_h_sum = 0;

        // cmd, t, t_ok, h, h_ok, typed, mean_t, mean_h, mean_ok, fill
        put_row(CMD_CLEAR, 'h5A5, 1, 'h3FF, 1,  1,     0,    0, 0, 0);
        put_row(CMD_ADD,   1250,  1, 1000,  1,  1,  1250, 1000, 1, 1);
        put_row(CMD_CLEAR, 0,     0, 0,     0,  1,     0,    0, 0, 0);
        put_row(CMD_ADD,   -400,  1, 0,     1,  1,  -400,    0, 1, 1);
        put_row(CMD_CLEAR, -1,    1, 1023,  1,  1,     0,    0, 0, 0);
        put_row(CMD_ADD,   2047,  1, 1023,  1,  1,  2047, 1023, 1, 1);
        put_row(CMD_CLEAR, 0,     0, 0,     0,  1,     0,    0, 0, 0);
        put_row(CMD_ADD,   -2048, 1, 1023,  1,  1, -2048, 1023, 1, 1);
        put_row(CMD_ADD,   2047,  0, 1023,  0,  0,     0,    0, 0, 0);
        put_row(CMD_ADD,   1,     1, 1,     1,  0,     0,    0, 0, 0);
        put_row(CMD_CLEAR, 0,     0, 0,     0,  1,     0,    0, 0, 0);
        put_row(CMD_CLEAR, 0,     0, 0,     0,  1,     0,    0, 0, 0);
        put_row(CMD_ADD,   'h7FF, 0, 'h3FF, 0,  1,     0,    0, 1, 1);
        put_row(CMD_ADD,   -1,    1, 1,     1,  0,     0,    0, 0, 0);
        put_row(CMD_CLEAR, 0,     0, 0,     0,  1,     0,    0, 0, 0);
        put_row(CMD_ADD,   -1,    1, 1,     1,  1,    -1,    1, 1, 1);
        put_row(CMD_ADD,   0,     1, 0,     1,  0,     0,    0, 0, 0);
        put_row(CMD_ADD,   -3,    1, 2,     1,  0,     0,    0, 0, 0);
        put_row(CMD_ADD,   5,     0, 7,     1,  0,     0,    0, 0, 0);
        put_row(CMD_ADD,   1250,  1, 0,     0,  0,     0,    0, 0, 0);

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (directed_rows[i])
            send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

        run_random(PHASE_ITEMS, 0, 0);
        run_random(PHASE_ITEMS, 68, 0);
        run_random(PHASE_ITEMS, 0, 68);
        run_random(PHASE_ITEMS, 38, 38);

        // Fill the block behind a stalled receiver, twice.
        -> hold_start;
        run_random(PHASE_ITEMS / 2, 0, 0);
        -> hold_start;
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2, 0, 0);

        sample_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (mean_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (failures == 0 && mean_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: dual_channel_window_average.f
+incdir+rtl/core
rtl/core/dcwa_pkg.sv
rtl/core/dcwa_if.sv
rtl/core/dcwa_ring.sv
rtl/core/dcwa_div.sv
rtl/core/dual_channel_window_average.sv
tb/sv/tb_top.sv
